// ----- hw/rtl/jqfl_pkg.sv -----
// ----------------------------------------------------------------------------
// Job queue package
// Shared constants, codes and helper functions for the job queue with free
// list: slot pool size, pointer widths, request kinds and response status.
// ----------------------------------------------------------------------------
package jqfl_pkg;

   // Number of job slots in the pool.
   localparam int SLOT_COUNT = 16;

   // Fixed field widths of the request and response transactions.
   localparam int KIND_W   = 2;
   localparam int STATUS_W = 2;
   localparam int SLOT_W   = 4;
   localparam int FUNC_W   = 32;
   localparam int PARAM_W  = 64;
   localparam int PAY_W    = FUNC_W + PARAM_W;

   // Memory index width and list pointer width (a pointer also holds null).
   localparam int ADDR_W = $clog2(SLOT_COUNT);
   localparam int PTR_W  = $clog2(SLOT_COUNT + 1);

   // The null link is the value SLOT_COUNT.
   localparam logic [PTR_W-1:0] NULL_LINK = PTR_W'(SLOT_COUNT);

   typedef logic [KIND_W-1:0]   kind_type;
   typedef logic [STATUS_W-1:0] status_type;
   typedef logic [SLOT_W-1:0]   slot_type;
   typedef logic [FUNC_W-1:0]   func_type;
   typedef logic [PARAM_W-1:0]  param_type;
   typedef logic [PTR_W-1:0]    ptr_type;
   typedef logic [ADDR_W-1:0]   addr_type;

   // Request kinds.
   localparam kind_type KIND_SCHEDULE = 2'd0;
   localparam kind_type KIND_ACQUIRE  = 2'd1;
   localparam kind_type KIND_FREE     = 2'd2;
   localparam kind_type KIND_NOP      = 2'd3;

   // Response status codes.
   localparam status_type STATUS_OK        = 2'd0;
   localparam status_type STATUS_EXHAUSTED = 2'd1;
   localparam status_type STATUS_EMPTY     = 2'd2;

   // A pointer names a slot when it is below the pool size; anything else
   // counts as null.
   function automatic logic is_slot(input ptr_type ptr);
      return 32'(ptr) < 32'(SLOT_COUNT);
   endfunction

endpackage

// ----- hw/rtl/jqfl_req_if.sv -----
// ----------------------------------------------------------------------------
// Job queue request channel
// Valid/ready channel that carries one request transaction to the queue.
// ----------------------------------------------------------------------------
interface jqfl_req_if;
   logic                 valid;
   logic                 ready;
   jqfl_pkg::kind_type   kind;
   logic                 priority_req;
   jqfl_pkg::func_type   job_function;
   jqfl_pkg::param_type  job_param;
   jqfl_pkg::slot_type   release_slot;

   modport source (
      output valid, kind, priority_req, job_function, job_param, release_slot,
      input  ready
   );

   modport sink (
      input  valid, kind, priority_req, job_function, job_param, release_slot,
      output ready
   );
endinterface

// ----- hw/rtl/jqfl_rsp_if.sv -----
// ----------------------------------------------------------------------------
// Job queue response channel
// Valid/ready channel that carries one response transaction from the queue.
// ----------------------------------------------------------------------------
interface jqfl_rsp_if;
   logic                 valid;
   logic                 ready;
   jqfl_pkg::status_type status;
   jqfl_pkg::slot_type   slot_index;
   jqfl_pkg::func_type   out_function;
   jqfl_pkg::param_type  out_param;

   modport source (
      output valid, status, slot_index, out_function, out_param,
      input  ready
   );

   modport sink (
      input  valid, status, slot_index, out_function, out_param,
      output ready
   );
endinterface

// ----- hw/rtl/jqfl_ram.sv -----
// ----------------------------------------------------------------------------
// Job queue RAM
// Generic single-write, single-read synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module jqfl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

// ----- hw/rtl/job_queue_with_free_list.sv -----
// ----------------------------------------------------------------------------
// Job queue with free list
// A pool of job slots threaded through one link memory into a free list and
// a pending queue, with a payload memory holding each slot's job.
// ----------------------------------------------------------------------------
// Each request transaction gives exactly one response transaction. Schedule
// takes the first free slot, stores the function handle and parameter word in
// it and links it at the queue tail, or at the head when priority_req is set
// and the queue is not empty; it answers with the slot, or with status pool
// exhausted when no slot is free. Acquire pops the queue head and answers with
// its slot and stored job, or with status queue empty. Free pushes
// release_slot onto the free list and echoes it; a slot outside the pool is
// ignored, and double frees are not checked. Kind 3 does nothing and answers
// with all fields zero. One transaction is in flight at a time: the link and
// payload memories are read in the acceptance cycle and written back in the
// execute state, once the output register is free. A schedule appended behind
// a non-empty queue also passes through the tail-link state, because the link
// memory has one write port and two entries change. A finished response waits
// in the output register while the next request is accepted; the block stalls
// only if a second response is ready before the first is taken. After reset
// the block is ready at once: link entries that were never written read as
// their reset value through a row of valid bits.
// ----------------------------------------------------------------------------
module job_queue_with_free_list (
   input  logic       clock,
   input  logic       reset,
   jqfl_req_if.sink   req_chan,
   jqfl_rsp_if.source rsp_chan
);

   // Sequencer states.
   localparam logic [1:0] ST_IDLE = 2'd0;  // waiting for a request
   localparam logic [1:0] ST_EXEC = 2'd1;  // read data back, write updates
   localparam logic [1:0] ST_TAIL = 2'd2;  // link the old tail to the new slot

   logic [1:0] state_ff, state_in;

   // Captured request.
   jqfl_pkg::kind_type  kind_ff, kind_in;
   logic                prio_ff, prio_in;
   jqfl_pkg::func_type  func_ff, func_in;
   jqfl_pkg::param_type param_ff, param_in;
   jqfl_pkg::slot_type  rel_ff, rel_in;
   jqfl_pkg::addr_type  rd_addr_ff, rd_addr_in;
   jqfl_pkg::addr_type  tail_addr_ff, tail_addr_in;

   // List pointers.
   jqfl_pkg::ptr_type free_head_ff, free_head_in;
   jqfl_pkg::ptr_type queue_head_ff, queue_head_in;
   jqfl_pkg::ptr_type queue_tail_ff, queue_tail_in;

   // One valid bit per link entry; an entry not yet written reads as its
   // reset value, which is its own index plus one (null for the last one).
   logic [jqfl_pkg::SLOT_COUNT-1:0] link_valid_ff, link_valid_in;

   // Response register.
   logic                 rsp_valid_ff, rsp_valid_in;
   jqfl_pkg::status_type rsp_status_ff, rsp_status_in;
   jqfl_pkg::slot_type   rsp_slot_ff, rsp_slot_in;
   jqfl_pkg::func_type   rsp_func_ff, rsp_func_in;
   jqfl_pkg::param_type  rsp_param_ff, rsp_param_in;

   // Memory ports.
   logic                        link_we;
   jqfl_pkg::addr_type          link_wr_addr;
   jqfl_pkg::ptr_type           link_wr_data;
   jqfl_pkg::ptr_type           link_q;
   logic                        pay_we;
   logic [jqfl_pkg::PAY_W-1:0]  pay_q;
   jqfl_pkg::addr_type          mem_rd_addr;

   logic              req_fire;
   logic              out_free;
   logic              rel_in_pool;
   jqfl_pkg::ptr_type link_next;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_fire       = req_chan.valid && req_chan.ready;

   // The response register can take a new result when it is empty or when
   // its current transaction completes in this cycle.
   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   // Acquire reads the queue head; every other kind reads the free head.
   // Reads are only enabled on acceptance, so the read data holds while the
   // sequencer waits for the response register.
   assign mem_rd_addr = (req_chan.kind == jqfl_pkg::KIND_ACQUIRE)
                      ? queue_head_ff[jqfl_pkg::ADDR_W-1:0]
                      : free_head_ff[jqfl_pkg::ADDR_W-1:0];

   // Link read data, with unwritten entries replaced by their reset value.
   assign link_next = link_valid_ff[rd_addr_ff]
                    ? link_q
                    : jqfl_pkg::PTR_W'(rd_addr_ff) + jqfl_pkg::PTR_W'(1);

   assign rel_in_pool = 32'(rel_ff) < 32'(jqfl_pkg::SLOT_COUNT);

   jqfl_ram #(
      .WIDTH (jqfl_pkg::PTR_W),
      .DEPTH (jqfl_pkg::SLOT_COUNT)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (link_we),
      .wr_addr (link_wr_addr),
      .wr_data (link_wr_data),
      .rd_en   (req_fire),
      .rd_addr (mem_rd_addr),
      .rd_data (link_q)
   );

   jqfl_ram #(
      .WIDTH (jqfl_pkg::PAY_W),
      .DEPTH (jqfl_pkg::SLOT_COUNT)
   ) u_pay_ram (
      .clock   (clock),
      .wr_en   (pay_we),
      .wr_addr (free_head_ff[jqfl_pkg::ADDR_W-1:0]),
      .wr_data ({func_ff, param_ff}),
      .rd_en   (req_fire),
      .rd_addr (mem_rd_addr),
      .rd_data (pay_q)
   );

   // Request capture.
   always_comb begin
      kind_in    = kind_ff;
      prio_in    = prio_ff;
      func_in    = func_ff;
      param_in   = param_ff;
      rel_in     = rel_ff;
      rd_addr_in = rd_addr_ff;
      if (req_fire) begin
         kind_in    = req_chan.kind;
         prio_in    = req_chan.priority_req;
         func_in    = req_chan.job_function;
         param_in   = req_chan.job_param;
         rel_in     = req_chan.release_slot;
         rd_addr_in = mem_rd_addr;
      end
   end

   // Sequencer: read-modify-write of the lists.
   always_comb begin
      state_in      = state_ff;
      free_head_in  = free_head_ff;
      queue_head_in = queue_head_ff;
      queue_tail_in = queue_tail_ff;
      tail_addr_in  = tail_addr_ff;
      link_we       = 1'b0;
      link_wr_addr  = free_head_ff[jqfl_pkg::ADDR_W-1:0];
      link_wr_data  = jqfl_pkg::NULL_LINK;
      pay_we        = 1'b0;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_func_in   = rsp_func_ff;
      rsp_param_in  = rsp_param_ff;

      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_EXEC;
            end
         end

         ST_EXEC: begin
            if (out_free) begin
               state_in      = ST_IDLE;
               rsp_valid_in  = 1'b1;
               rsp_status_in = jqfl_pkg::STATUS_OK;
               rsp_slot_in   = '0;
               rsp_func_in   = '0;
               rsp_param_in  = '0;
               case (kind_ff)
                  jqfl_pkg::KIND_SCHEDULE: begin
                     if (!jqfl_pkg::is_slot(free_head_ff)) begin
                        rsp_status_in = jqfl_pkg::STATUS_EXHAUSTED;
                     end else begin
                        rsp_slot_in  = jqfl_pkg::SLOT_W'(free_head_ff);
                        free_head_in = link_next;
                        pay_we       = 1'b1;
                        link_we      = 1'b1;
                        if (!jqfl_pkg::is_slot(queue_head_ff)) begin
                           // Empty queue: the slot becomes head and tail.
                           queue_head_in = free_head_ff;
                           queue_tail_in = free_head_ff;
                        end else if (prio_ff) begin
                           link_wr_data  = queue_head_ff;
                           queue_head_in = free_head_ff;
                        end else begin
                           // Append: the old tail is linked in the next cycle.
                           queue_tail_in = free_head_ff;
                           tail_addr_in  = queue_tail_ff[jqfl_pkg::ADDR_W-1:0];
                           if (jqfl_pkg::is_slot(queue_tail_ff)) begin
                              state_in = ST_TAIL;
                           end
                        end
                     end
                  end

                  jqfl_pkg::KIND_ACQUIRE: begin
                     if (!jqfl_pkg::is_slot(queue_head_ff)) begin
                        rsp_status_in = jqfl_pkg::STATUS_EMPTY;
                     end else begin
                        rsp_slot_in   = jqfl_pkg::SLOT_W'(queue_head_ff);
                        rsp_func_in   = pay_q[jqfl_pkg::PAY_W-1:jqfl_pkg::PARAM_W];
                        rsp_param_in  = pay_q[jqfl_pkg::PARAM_W-1:0];
                        queue_head_in = link_next;
                     end
                  end

                  jqfl_pkg::KIND_FREE: begin
                     rsp_slot_in = rel_ff;
                     if (rel_in_pool) begin
                        link_we      = 1'b1;
                        link_wr_addr = jqfl_pkg::ADDR_W'(rel_ff);
                        link_wr_data = free_head_ff;
                        free_head_in = jqfl_pkg::PTR_W'(rel_ff);
                     end
                  end

                  default: begin
                  end
               endcase
            end
         end

         ST_TAIL: begin
            // The queue tail already names the new slot.
            link_we      = 1'b1;
            link_wr_addr = tail_addr_ff;
            link_wr_data = queue_tail_ff;
            state_in     = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      link_valid_in = link_valid_ff;
      if (link_we) begin
         link_valid_in[link_wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         free_head_ff  <= '0;
         queue_head_ff <= jqfl_pkg::NULL_LINK;
         queue_tail_ff <= jqfl_pkg::NULL_LINK;
         link_valid_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         free_head_ff  <= free_head_in;
         queue_head_ff <= queue_head_in;
         queue_tail_ff <= queue_tail_in;
         link_valid_ff <= link_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      prio_ff       <= prio_in;
      func_ff       <= func_in;
      param_ff      <= param_in;
      rel_ff        <= rel_in;
      rd_addr_ff    <= rd_addr_in;
      tail_addr_ff  <= tail_addr_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_func_ff   <= rsp_func_in;
      rsp_param_ff  <= rsp_param_in;
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.status       = rsp_status_ff;
   assign rsp_chan.slot_index   = rsp_slot_ff;
   assign rsp_chan.out_function = rsp_func_ff;
   assign rsp_chan.out_param    = rsp_param_ff;

   // An accepted request always moves on to the write-back cycle.
   a_fire_to_exec: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff == ST_EXEC)
      else $error("accepted request did not enter write-back");

   // The tail link cycle only follows the write-back of an append.
   a_tail_after_exec: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_TAIL |-> $past(state_ff) == ST_EXEC && $past(kind_ff) ==
         jqfl_pkg::KIND_SCHEDULE)
      else $error("tail link cycle without a preceding append");

   // Link writes never land outside the pool.
   a_link_wr_in_pool: assert property (@(posedge clock) disable iff (reset)
      link_we |-> 32'(link_wr_addr) < 32'(jqfl_pkg::SLOT_COUNT))
      else $error("link write outside the slot pool");

   // A waiting response is never overwritten by the next result.
   a_rsp_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_chan.ready |-> rsp_valid_in && !(state_ff == ST_EXEC
         && state_in != ST_EXEC))
      else $error("response register overwritten while full");

endmodule

// ----- test/testbench.sv -----
// ----------------------------------------------------------------------------
// Job queue with free list testbench
// Drives schedule, acquire, free and no-op requests into the job queue and
// checks every response against a cycle-free model of the slot pool, under
// several patterns of sender gaps and receiver back-pressure.
// ----------------------------------------------------------------------------
module testbench;

   // Cycles the receiver holds off in one stretch to back up the pipeline.
   localparam int HOLD_CYCLES = 300;
   // Cycles without any transaction before the run is declared hung.
   localparam int STALL_LIMIT = 4000;
   // Cycles to wait after the last response for stray extra responses.
   localparam int DRAIN_CYCLES = 20;
   // Random requests per idling phase; four phases follow the directed part.
   localparam int PHASE_ITEMS = 345;
   // Random requests between changes of the schedule/acquire balance.
   localparam int BIAS_BLOCK = 40;

   // One request transaction as the sender sees it.
   typedef struct packed {
      jqfl_pkg::kind_type  kind;
      logic                priority_req;
      jqfl_pkg::func_type  job_function;
      jqfl_pkg::param_type job_param;
      jqfl_pkg::slot_type  release_slot;
   } job_req_type;

   // One response transaction as the receiver sees it.
   typedef struct packed {
      jqfl_pkg::status_type status;
      jqfl_pkg::slot_type   slot_index;
      jqfl_pkg::func_type   out_function;
      jqfl_pkg::param_type  out_param;
   } job_rsp_type;

   // Complete state of the slot pool: the shared link table, the payload
   // stores and the three list pointers.
   typedef struct packed {
      logic [jqfl_pkg::SLOT_COUNT-1:0][jqfl_pkg::PTR_W-1:0]   link;
      logic [jqfl_pkg::SLOT_COUNT-1:0][jqfl_pkg::FUNC_W-1:0]  fn_mem;
      logic [jqfl_pkg::SLOT_COUNT-1:0][jqfl_pkg::PARAM_W-1:0] par_mem;
      jqfl_pkg::ptr_type                                      q_head;
      jqfl_pkg::ptr_type                                      q_tail;
      jqfl_pkg::ptr_type                                      f_head;
   } pool_state_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   jqfl_req_if req_bus ();
   jqfl_rsp_if rsp_bus ();

   job_queue_with_free_list uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // Pool model
   // ------------------------------------------------------------------------

   // A pointer names a real slot only below the pool size; the null link and
   // any corrupt value above it both mean "no slot".
   function automatic logic in_pool(input jqfl_pkg::ptr_type ptr);
      return ptr < jqfl_pkg::PTR_W'(jqfl_pkg::SLOT_COUNT);
   endfunction

   // State right after reset: every slot on the free list in index order,
   // the pending queue empty.
   function automatic pool_state_type pool_reset_state();
      pool_state_type st;
      st = '0;
      for (int i = 0; i < jqfl_pkg::SLOT_COUNT; i++) begin
         st.link[i] = jqfl_pkg::PTR_W'(i + 1);
      end
      st.link[jqfl_pkg::SLOT_COUNT-1] = jqfl_pkg::NULL_LINK;
      st.q_head = jqfl_pkg::NULL_LINK;
      st.q_tail = jqfl_pkg::NULL_LINK;
      st.f_head = '0;
      return st;
   endfunction

   // Applies one request to the pool and works out the response it gives.
   function automatic void pool_step(inout pool_state_type st,
                                     input job_req_type rq,
                                     output job_rsp_type rs);
      jqfl_pkg::ptr_type  s;
      jqfl_pkg::addr_type a;
      rs = '0;
      case (rq.kind)
         jqfl_pkg::KIND_SCHEDULE: begin
            s = st.f_head;
            if (!in_pool(s)) begin
               // The pool is used up: nothing changes.
               rs.status = jqfl_pkg::STATUS_EXHAUSTED;
            end else begin
               a = jqfl_pkg::addr_type'(s);
               st.f_head     = st.link[a];
               st.fn_mem[a]  = rq.job_function;
               st.par_mem[a] = rq.job_param;
               if (!in_pool(st.q_head)) begin
                  // An empty queue takes the slot as both head and tail,
                  // whatever the priority and whatever the stale tail says.
                  st.link[a] = jqfl_pkg::NULL_LINK;
                  st.q_head  = s;
                  st.q_tail  = s;
               end else if (rq.priority_req) begin
                  st.link[a] = st.q_head;
                  st.q_head  = s;
               end else begin
                  st.link[a] = jqfl_pkg::NULL_LINK;
                  if (in_pool(st.q_tail)) begin
                     st.link[jqfl_pkg::addr_type'(st.q_tail)] = s;
                  end
                  st.q_tail = s;
               end
               rs.status     = jqfl_pkg::STATUS_OK;
               rs.slot_index = jqfl_pkg::slot_type'(s);
            end
         end
         jqfl_pkg::KIND_ACQUIRE: begin
            s = st.q_head;
            if (!in_pool(s)) begin
               rs.status = jqfl_pkg::STATUS_EMPTY;
            end else begin
               a = jqfl_pkg::addr_type'(s);
               st.q_head       = st.link[a];
               rs.status       = jqfl_pkg::STATUS_OK;
               rs.slot_index   = jqfl_pkg::slot_type'(s);
               rs.out_function = st.fn_mem[a];
               rs.out_param    = st.par_mem[a];
            end
         end
         jqfl_pkg::KIND_FREE: begin
            // Double and stray frees are pushed like any other; only a slot
            // outside the pool is dropped, and the index is echoed anyway.
            if (in_pool(jqfl_pkg::PTR_W'(rq.release_slot))) begin
               st.link[jqfl_pkg::addr_type'(rq.release_slot)] = st.f_head;
               st.f_head = jqfl_pkg::PTR_W'(rq.release_slot);
            end
            rs.slot_index = rq.release_slot;
         end
         default: begin
         end
      endcase
   endfunction

   // ------------------------------------------------------------------------
   // Shared testbench state
   // ------------------------------------------------------------------------

   job_req_type job_backlog [$];   // requests waiting to be offered
   job_rsp_type awaited_rsp [$];   // responses owed by the block, oldest first

   // The pool as the block sees it, advanced once per accepted request.
   pool_state_type pool_model;
   // A second copy advanced as requests are generated, so that the stimulus
   // knows which slots the application currently holds.
   pool_state_type pool_plan;
   logic [jqfl_pkg::SLOT_COUNT-1:0] held_slots;

   int issued_count   = 0;
   int accepted_count = 0;
   int response_count = 0;
   int mismatch_count = 0;

   // Percentages of cycles in which the sender idles and the receiver stalls.
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;

   // Each increment asks the receiver for one long hold-off.
   int hold_calls = 0;

   // ------------------------------------------------------------------------
   // Driver
   // ------------------------------------------------------------------------
   // The driver keeps the request it is offering in offered_req. A
   // transaction completes when valid and ready are both high at an edge;
   // the model is advanced right then, which fixes the order of responses.
   // A new request is taken from the backlog whenever the channel is free,
   // unless the sender decides to idle in this cycle. Valid is assigned at
   // most once per edge, so a back-to-back request keeps it high.

   job_req_type offered_req;

   always @(posedge clock) begin
      job_rsp_type predicted;
      if (reset) begin
         req_bus.valid        <= 1'b0;
         req_bus.kind         <= jqfl_pkg::KIND_NOP;
         req_bus.priority_req <= 1'b0;
         req_bus.job_function <= '0;
         req_bus.job_param    <= '0;
         req_bus.release_slot <= '0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            pool_step(pool_model, offered_req, predicted);
            awaited_rsp.push_back(predicted);
            accepted_count++;
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (job_backlog.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               offered_req           = job_backlog.pop_front();
               req_bus.kind         <= offered_req.kind;
               req_bus.priority_req <= offered_req.priority_req;
               req_bus.job_function <= offered_req.job_function;
               req_bus.job_param    <= offered_req.job_param;
               req_bus.release_slot <= offered_req.release_slot;
               req_bus.valid        <= 1'b1;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Monitor
   // ------------------------------------------------------------------------
   // Every response transaction is compared field by field with the oldest
   // owed response. Ready is chosen per cycle from the stall percentage, or
   // held low for a long stretch when the stimulus asks for a hold-off; that
   // stretch is counted here so that its length does not depend on anything
   // the sender does.

   int hold_left = 0;
   int hold_seen = 0;

   always @(posedge clock) begin
      job_rsp_type got;
      job_rsp_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.status       = rsp_bus.status;
            got.slot_index   = rsp_bus.slot_index;
            got.out_function = rsp_bus.out_function;
            got.out_param    = rsp_bus.out_param;
            if (awaited_rsp.size() == 0) begin
               if (mismatch_count < 10) begin
                  $display("response %0d arrived with none owed: %s %0d slot %0d fn %h param %h",
                           response_count, "status", got.status, got.slot_index,
                           got.out_function, got.out_param);
               end
               mismatch_count++;
            end else begin
               want = awaited_rsp.pop_front();
               if (got.status !== want.status || got.slot_index !== want.slot_index ||
                   got.out_function !== want.out_function ||
                   got.out_param !== want.out_param) begin
                  if (mismatch_count < 10) begin
                     $display("response %0d mismatch: expected status %0d slot %0d %s",
                              response_count, want.status, want.slot_index,
                              $sformatf("fn %h param %h", want.out_function,
                                        want.out_param));
                     $display("response %0d mismatch:      got status %0d slot %0d %s",
                              response_count, got.status, got.slot_index,
                              $sformatf("fn %h param %h", got.out_function,
                                        got.out_param));
                  end
                  mismatch_count++;
               end
            end
            response_count++;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else if (hold_seen != hold_calls) begin
            hold_seen = hold_calls;
            hold_left = HOLD_CYCLES;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   // ------------------------------------------------------------------------
   // Watchdog
   // ------------------------------------------------------------------------
   // Counts cycles in which no transaction completes on either channel. The
   // longest honest quiet stretch is the receiver hold-off, well below the
   // limit.

   int quiet_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles + 1 >= STALL_LIMIT) begin
            $display("Some tests failed");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------------

   // A request of the given kind with every field random; the block must
   // ignore the fields that the kind does not use.
   function automatic job_req_type random_req(input jqfl_pkg::kind_type kind);
      job_req_type rq;
      rq.kind         = kind;
      rq.priority_req = 1'($urandom_range(1));
      rq.job_function = $urandom;
      rq.job_param    = {$urandom, $urandom};
      rq.release_slot = jqfl_pkg::slot_type'($urandom_range(15));
      // Now and then the payload sits at one of its extremes.
      case ($urandom_range(15))
         0: begin
            rq.job_function = '0;
            rq.job_param    = '0;
         end
         1: begin
            rq.job_function = '1;
            rq.job_param    = '1;
         end
         default: begin
         end
      endcase
      return rq;
   endfunction

   // Plans a request against the generation-side pool, keeps track of which
   // slots the application holds, and puts the request in the backlog.
   task automatic queue_job(input job_req_type rq);
      job_rsp_type r;
      pool_step(pool_plan, rq, r);
      if (rq.kind == jqfl_pkg::KIND_ACQUIRE && r.status == jqfl_pkg::STATUS_OK) begin
         held_slots[r.slot_index] = 1'b1;
      end
      if (rq.kind == jqfl_pkg::KIND_FREE) begin
         held_slots[rq.release_slot] = 1'b0;
      end
      job_backlog.push_back(rq);
      issued_count++;
   endtask

   // Picks one of the slots the application holds, searching from a random
   // starting point. Only called when at least one is held.
   function automatic jqfl_pkg::slot_type pick_held();
      int start;
      start = $urandom_range(jqfl_pkg::SLOT_COUNT - 1);
      for (int i = 0; i < jqfl_pkg::SLOT_COUNT; i++) begin
         if (held_slots[(start + i) % jqfl_pkg::SLOT_COUNT]) begin
            return jqfl_pkg::slot_type'((start + i) % jqfl_pkg::SLOT_COUNT);
         end
      end
      return '0;
   endfunction

   // Mostly well-formed traffic: schedules, acquires, and frees of slots that
   // were acquired and not yet returned. sched_pct sets the balance between
   // filling and draining. A few percent are no-ops and stray frees of any
   // slot, which may tangle the lists.
   function automatic job_req_type next_random_req(input int sched_pct);
      job_req_type rq;
      int          noise;
      int          pick;
      noise = $urandom_range(99);
      pick  = $urandom_range(99);
      if (noise < 3) begin
         rq = random_req(jqfl_pkg::KIND_NOP);
      end else if (noise < 5) begin
         rq = random_req(jqfl_pkg::KIND_FREE);
      end else if (pick < sched_pct) begin
         rq = random_req(jqfl_pkg::KIND_SCHEDULE);
      end else if (held_slots != '0 && $urandom_range(1) == 1) begin
         rq = random_req(jqfl_pkg::KIND_FREE);
         rq.release_slot = pick_held();
      end else begin
         rq = random_req(jqfl_pkg::KIND_ACQUIRE);
      end
      return rq;
   endfunction

   initial begin
      job_req_type rq;
      int          sched_pct;

      pool_model = pool_reset_state();
      pool_plan  = pool_reset_state();
      held_slots = '0;

      // Directed part. No free comes before every slot has been scheduled
      // once, so no acquire can ever pop a slot whose payload was never
      // written, however tangled the lists become later.

      // Acquire from the empty queue straight after reset.
      queue_job(random_req(jqfl_pkg::KIND_ACQUIRE));
      // A no-op with every field at all ones.
      rq = '1;
      rq.kind = jqfl_pkg::KIND_NOP;
      queue_job(rq);
      // Fill the whole pool. The first schedule asks for priority on an empty
      // queue, the next two carry extreme payloads, then priority alternates.
      for (int i = 0; i < jqfl_pkg::SLOT_COUNT; i++) begin
         rq = random_req(jqfl_pkg::KIND_SCHEDULE);
         rq.priority_req = (i % 2 == 0);
         if (i == 1) begin
            rq.job_function = '0;
            rq.job_param    = '0;
         end else if (i == 2) begin
            rq.job_function = '1;
            rq.job_param    = '1;
         end
         queue_job(rq);
      end
      // One more schedule finds the pool exhausted.
      rq = random_req(jqfl_pkg::KIND_SCHEDULE);
      rq.priority_req = 1'b1;
      queue_job(rq);
      // Pop a few, return one of them, then return it a second time.
      for (int i = 0; i < 3; i++) begin
         queue_job(random_req(jqfl_pkg::KIND_ACQUIRE));
      end
      rq = random_req(jqfl_pkg::KIND_FREE);
      rq.release_slot = pick_held();
      queue_job(rq);
      queue_job(rq);
      queue_job(random_req(jqfl_pkg::KIND_SCHEDULE));

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Random part in four idling phases: none, sender idle, receiver
      // stalling, and both together.
      for (int phase = 0; phase < 4; phase++) begin
         @(negedge clock);
         case (phase)
            0: begin
               send_idle_pct = 0;
               rsp_stall_pct = 0;
            end
            1: begin
               send_idle_pct = 63;
               rsp_stall_pct = 0;
            end
            2: begin
               send_idle_pct = 0;
               rsp_stall_pct = 63;
            end
            default: begin
               send_idle_pct = 27;
               rsp_stall_pct = 27;
            end
         endcase
         sched_pct = 50;
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if (i % BIAS_BLOCK == 0) begin
               sched_pct = $urandom_range(65, 25);
            end
            queue_job(next_random_req(sched_pct));
         end
         if (phase == 0) begin
            // Halfway through the phase without idling, the receiver holds
            // off for a long stretch while the sender keeps offering, so the
            // block fills up and stalls its input.
            while (job_backlog.size() > PHASE_ITEMS / 2) @(negedge clock);
            hold_calls++;
         end
         while (job_backlog.size() > 0) @(negedge clock);
         if (phase == 1) begin
            // The sender pauses until every owed response has come back.
            while (accepted_count != issued_count || awaited_rsp.size() != 0) begin
               @(negedge clock);
            end
         end
      end

      // Wait for everything to be accepted and answered, then a little
      // longer to catch any response the block should not have sent.
      while (accepted_count != issued_count || awaited_rsp.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && awaited_rsp.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
